/* hw/rtl/mqtt_publish_deframer_core_defines.svh */
// assertion helpers shared by the checker
`ifndef MQTT_PUBLISH_DEFRAMER_CORE_DEFINES_SVH
`define MQTT_PUBLISH_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is applied
`define MPD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, live during reset too
`define MPD_ASSERT_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

/* hw/rtl/mpd_pkg.sv */
package mpd_pkg;

  localparam logic [3:0]  PUBLISH_TYPE = 4'h3;
  localparam logic [16:0] CNT_MAX      = 17'h1FFFF;
  localparam logic [16:0] LAST_IN_LIMIT = 17'h0FFFE;
  localparam logic [16:0] MIN_FRAME_M1 = 17'd4;
  localparam logic [2:0]  LEN_BYTES_MAX = 3'd4;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_NOT_PUBLISH  = 4'd2,
    ST_LEN_TRUNC    = 4'd3,
    ST_LEN_TOO_LONG = 4'd4,
    ST_REM_EXCEEDS  = 4'd5,
    ST_NO_TOPIC_LEN = 4'd6,
    ST_TOPIC_TRUNC  = 4'd7,
    ST_REM_BELOW    = 4'd8,
    ST_OVER_LIMIT   = 4'd9
  } status_t;

  // everything the back end needs to judge one finished frame
  typedef struct packed {
    logic [16:0] cnt;
    logic        is_pub;
    logic        overrun;
    logic        done;
    logic [2:0]  lfb;
    logic [27:0] rem;
    logic [15:0] topic;
  } frame_sum_t;

endpackage

/* hw/rtl/mpd_front.sv */
module mpd_front
  import mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       sum_push,
  output frame_sum_t sum
);

  logic [16:0] cnt_r, cnt_nxt;
  logic        is_pub_r, is_pub_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic [2:0]  lfb_r, lfb_nxt;
  logic        done_r, done_nxt;
  logic        ovr_r, ovr_nxt;
  logic [15:0] topic_r, topic_nxt;
  logic [27:0] rem_part;
  logic [16:0] av;

  always_comb begin
    case (lfb_r[1:0])
      2'd0:    rem_part = {21'd0, data_byte[6:0]};
      2'd1:    rem_part = {14'd0, data_byte[6:0], 7'd0};
      2'd2:    rem_part = {7'd0, data_byte[6:0], 14'd0};
      default: rem_part = {data_byte[6:0], 21'd0};
    endcase
  end

  assign av = {14'd0, lfb_r} + 17'd1;

  always_comb begin
    is_pub_nxt = is_pub_r;
    rem_nxt    = rem_r;
    lfb_nxt    = lfb_r;
    done_nxt   = done_r;
    ovr_nxt    = ovr_r;
    topic_nxt  = topic_r;
    if (cnt_r == 17'd0) begin
      is_pub_nxt = (data_byte[7:4] == PUBLISH_TYPE);
    end else if (!done_r && !ovr_r) begin
      rem_nxt = rem_r | rem_part;
      lfb_nxt = lfb_r + 3'd1;
      if (!data_byte[7]) begin
        done_nxt = 1'b1;
      end else if (lfb_nxt >= LEN_BYTES_MAX) begin
        ovr_nxt = 1'b1;
      end
    end else if (done_r) begin
      if (cnt_r == av) begin
        topic_nxt[15:8] = data_byte;
      end else if (cnt_r == av + 17'd1) begin
        topic_nxt[7:0] = data_byte;
      end
    end
    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 17'd1;
  end

  assign sum_push = accept && last_byte;

  always_comb begin
    sum.cnt     = cnt_r;
    sum.is_pub  = is_pub_nxt;
    sum.overrun = ovr_nxt;
    sum.done    = done_nxt;
    sum.lfb     = lfb_nxt;
    sum.rem     = rem_nxt;
    sum.topic   = topic_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || sum_push) begin
      cnt_r    <= '0;
      is_pub_r <= 1'b0;
      rem_r    <= '0;
      lfb_r    <= '0;
      done_r   <= 1'b0;
      ovr_r    <= 1'b0;
      topic_r  <= '0;
    end else if (accept) begin
      cnt_r    <= cnt_nxt;
      is_pub_r <= is_pub_nxt;
      rem_r    <= rem_nxt;
      lfb_r    <= lfb_nxt;
      done_r   <= done_nxt;
      ovr_r    <= ovr_nxt;
      topic_r  <= topic_nxt;
    end
  end

endmodule

/* hw/rtl/mpd_queue.sv */
module mpd_queue
  import mpd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_sum_t wr_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output frame_sum_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_sum_t    slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/mpd_back.sv */
module mpd_back
  import mpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        sum_valid,
  input  frame_sum_t  sum,
  output logic        sum_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_status,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_topic_length
);

  logic        valid_r;
  status_t     status_r, status_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [16:0] flen;
  logic [16:0] av;
  logic [16:0] hdr_end;
  logic [16:0] topic_end;
  logic [28:0] rem_end;
  logic [16:0] topic_need;
  logic        load;

  assign flen       = sum.cnt + 17'd1;
  assign av         = {14'd0, sum.lfb} + 17'd1;
  assign hdr_end    = av + 17'd2;
  assign topic_end  = hdr_end + {1'b0, sum.topic};
  assign rem_end    = {1'b0, sum.rem} + {12'd0, av};
  assign topic_need = {1'b0, sum.topic} + 17'd2;

  always_comb begin
    status_nxt = ST_OK;
    off_nxt    = '0;
    plen_nxt   = '0;
    tlen_nxt   = '0;
    if (sum.cnt > LAST_IN_LIMIT) begin
      status_nxt = ST_OVER_LIMIT;
    end else if (sum.cnt < MIN_FRAME_M1) begin
      status_nxt = ST_SHORT;
    end else if (!sum.is_pub) begin
      status_nxt = ST_NOT_PUBLISH;
    end else if (sum.overrun) begin
      status_nxt = ST_LEN_TOO_LONG;
    end else if (!sum.done) begin
      status_nxt = ST_LEN_TRUNC;
    end else if (rem_end > {12'd0, flen}) begin
      status_nxt = ST_REM_EXCEEDS;
    end else if (hdr_end > flen) begin
      status_nxt = ST_NO_TOPIC_LEN;
    end else if (topic_end > flen) begin
      status_nxt = ST_TOPIC_TRUNC;
      tlen_nxt   = sum.topic;
    end else if (sum.rem < {11'd0, topic_need}) begin
      status_nxt = ST_REM_BELOW;
      tlen_nxt   = sum.topic;
    end else begin
      tlen_nxt = sum.topic;
      off_nxt  = topic_end[15:0];
      plen_nxt = sum.rem[15:0] - topic_need[15:0];
    end
  end

  // output register refills while its current result is being taken
  assign load    = sum_valid && (!valid_r || out_pop);
  assign sum_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      off_r    <= off_nxt;
      plen_r   <= plen_nxt;
      tlen_r   <= tlen_nxt;
    end
  end

  assign out_empty          = !valid_r;
  assign out_status         = status_r;
  assign out_payload_offset = off_r;
  assign out_payload_length = plen_r;
  assign out_topic_length   = tlen_r;

endmodule

/* hw/rtl/mqtt_publish_deframer_core.sv */
// MQTT PUBLISH frame deframer.
// Input queue port: one frame byte per transfer on in_data_byte, with
// in_last_byte high on the final byte of the frame. A transfer happens when
// in_push is high and in_full is low.
// Result queue port: one result per frame, given when the final byte is
// taken. The oldest result sits on out_status, out_payload_offset,
// out_payload_length and out_topic_length while out_empty is low; out_pop
// with out_empty low takes it.
// Throughput: one byte per cycle while in_full is low, set by the header tracker in
// the front end. A frame's summary is registered in the queue, then in the output register.
// Finished frames pass through a QUEUE_DEPTH-entry queue of frame summaries
// to the back end, which runs the status checks and loads an output
// register. When the receiver stalls, results pile up in that queue; once it
// is full, in_full goes high and holds off further bytes.
// Reset (synchronous, rst_n low) drops any partial frame and all pending
// results.
module mqtt_publish_deframer_core
  import mpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_status,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_topic_length
);

  frame_sum_t wr_sum, rd_sum;
  logic       accept;
  logic       sum_push;
  logic       q_empty;
  logic       sum_pop;

  assign accept = in_push && !in_full;

  mpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .sum_push  (sum_push),
    .sum       (wr_sum)
  );

  mpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (sum_push),
    .wr_data (wr_sum),
    .full    (in_full),
    .pop     (sum_pop),
    .empty   (q_empty),
    .rd_data (rd_sum)
  );

  mpd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .sum_valid          (!q_empty),
    .sum                (rd_sum),
    .sum_pop            (sum_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_topic_length   (out_topic_length)
  );

endmodule

/* hw/rtl/mpd_checker.sv */
`include "mqtt_publish_deframer_core_defines.svh"

module mpd_checker
  import mpd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic [3:0]  out_status,
  input logic [15:0] out_payload_offset,
  input logic [15:0] out_payload_length,
  input logic [15:0] out_topic_length
);

  logic shown;
  logic failed;
  logic topic_unused;
  logic payload_zero;

  assign shown        = !out_empty;
  assign failed       = shown && (out_status != ST_OK);
  // topic length only carries meaning for ok, topic truncated and rem below topic
  assign topic_unused = failed && (out_status != ST_TOPIC_TRUNC) &&
                        (out_status != ST_REM_BELOW);
  assign payload_zero = (out_payload_offset == 16'd0) && (out_payload_length == 16'd0);

  `MPD_ASSERT_NXT(a_reset_empty, clk, !rst_n, out_empty)
  `MPD_ASSERT_IMP(a_status_range, clk, rst_n, shown, out_status <= ST_OVER_LIMIT)
  `MPD_ASSERT_IMP(a_fail_no_payload, clk, rst_n, failed, payload_zero)
  `MPD_ASSERT_IMP(a_topic_only_valid, clk, rst_n, topic_unused, out_topic_length == 16'd0)

endmodule

bind mqtt_publish_deframer_core mpd_checker u_mpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_status         (out_status),
  .out_payload_offset (out_payload_offset),
  .out_payload_length (out_payload_length),
  .out_topic_length   (out_topic_length)
);

/* sim/testbench.sv */
module testbench;
  import mpd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1100;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    status_t     st;
    logic [15:0] offset;
    logic [15:0] plen;
    logic [15:0] tlen;
  } frame_verdict_t;

  // tracks the header of the frame in flight and keeps the verdicts still owed
  class deframe_scoreboard;
    logic [16:0] byte_cnt;
    bit          publish_seen;
    logic [27:0] rem_len;
    logic [2:0]  len_bytes;
    bit          len_done;
    bit          len_overrun;
    logic [15:0] topic_size;
    frame_verdict_t owed[$];
    int errors;
    int reports;

    function new();
      errors = 0;
      reports = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt = '0;
      publish_seen = 0;
      rem_len = '0;
      len_bytes = '0;
      len_done = 0;
      len_overrun = 0;
      topic_size = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned idx, flen, hdr_end, shift;
      frame_verdict_t v;
      idx = byte_cnt;
      if (idx == 0) begin
        publish_seen = (b[7:4] == PUBLISH_TYPE);
      end else if (!len_done && !len_overrun) begin
        shift = 7 * len_bytes[1:0];
        rem_len = rem_len + (28'(b[6:0]) << shift);
        len_bytes = len_bytes + 3'd1;
        if (!b[7]) len_done = 1;
        else if (len_bytes >= LEN_BYTES_MAX) len_overrun = 1;
      end else if (len_done) begin
        hdr_end = 1 + len_bytes;
        if (idx == hdr_end) topic_size[15:8] = b;
        else if (idx == hdr_end + 1) topic_size[7:0] = b;
      end
      if (byte_cnt != CNT_MAX) byte_cnt = byte_cnt + 17'd1;
      if (!last) return;

      flen = idx + 1;
      hdr_end = 1 + len_bytes;
      v.offset = '0;
      v.plen = '0;
      v.tlen = '0;
      if (idx > LAST_IN_LIMIT) v.st = ST_OVER_LIMIT;
      else if (idx < MIN_FRAME_M1) v.st = ST_SHORT;
      else if (!publish_seen) v.st = ST_NOT_PUBLISH;
      else if (len_overrun) v.st = ST_LEN_TOO_LONG;
      else if (!len_done) v.st = ST_LEN_TRUNC;
      else if (hdr_end + rem_len > flen) v.st = ST_REM_EXCEEDS;
      else if (hdr_end + 2 > flen) v.st = ST_NO_TOPIC_LEN;
      else if (hdr_end + 2 + topic_size > flen) begin
        v.st = ST_TOPIC_TRUNC;
        v.tlen = topic_size;
      end else if (rem_len < 2 + topic_size) begin
        v.st = ST_REM_BELOW;
        v.tlen = topic_size;
      end else begin
        v.st = ST_OK;
        v.tlen = topic_size;
        v.offset = 16'(hdr_end + 2 + topic_size);
        v.plen = 16'(rem_len - 2 - topic_size);
      end
      owed.push_back(v);
      clear_frame();
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      errors++;
      // keep the log readable when the block is badly off
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [3:0] st, logic [15:0] offset, logic [15:0] plen,
                               logic [15:0] tlen);
      frame_verdict_t v;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual status %0d", $time, st);
        return;
      end
      v = owed.pop_front();
      if (st !== v.st) report_field("status", v.st, st);
      if (offset !== v.offset) report_field("payload_offset", v.offset, offset);
      if (plen !== v.plen) report_field("payload_length", v.plen, plen);
      if (tlen !== v.tlen) report_field("topic_length", v.tlen, tlen);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_empty;
  logic        out_pop;
  logic [3:0]  out_status;
  logic [15:0] out_payload_offset;
  logic [15:0] out_payload_length;
  logic [15:0] out_topic_length;

  deframe_scoreboard sb = new();
  logic [7:0] frame_q[$];
  bit tx_burst;
  bit rx_burst;
  int bytes_sent;
  int idle_cycles;
  int rx_hold;

  mqtt_publish_deframer_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_topic_length   (out_topic_length)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_push && !in_full) sb.note_byte(in_data_byte, in_last_byte);
      if (out_pop && !out_empty)
        sb.check_result(out_status, out_payload_offset, out_payload_length, out_topic_length);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("mqtt_publish_deframer_core regression: fail");
        $finish;
      end
    end
  end

  // result side: pop with random stalls after each transfer
  always @(posedge clk) begin : rx_side
    int g;
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_hold = 0;
    end else if (out_pop && !out_empty) begin
      g = rx_burst ? 0 : pick_gap();
      rx_hold = g;
      out_pop <= (g == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_pop <= (rx_hold == 0);
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_q.size(); k++) push_byte(frame_q[k], k == frame_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // variable-byte length, padded with continuation bytes up to nb bytes
  function automatic void put_len(int unsigned v, int nb);
    int need, k;
    need = 1;
    while (need < 4 && (v >> (7 * need)) != 0) need++;
    if (nb < need) nb = need;
    for (k = 0; k < nb; k++)
      frame_q.push_back({(k < nb - 1), 7'((v >> (7 * k)) & 32'h7F)});
  endfunction

  function automatic void build_publish(int tl, int body, int nb, int unsigned rem);
    int k;
    frame_q.delete();
    frame_q.push_back({PUBLISH_TYPE, 4'($urandom)});
    put_len(rem, nb);
    frame_q.push_back(8'(tl >> 8));
    frame_q.push_back(8'(tl));
    for (k = 0; k < tl + body; k++) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void make_random_frame();
    int r, tl, pl, extra, nb, k, cut;
    r = $urandom_range(0, 99);
    tl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 8);
    pl = $urandom_range(0, 16);
    nb = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 1;
    extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (r < 55) begin
      build_publish(tl, pl + extra, nb, 2 + tl + pl);
    end else if (r < 65) begin
      build_publish(tl, pl, nb, 2 + tl + pl);
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end else if (r < 72) begin
      build_publish(tl, pl, nb, $urandom_range(0, 1 + tl));
    end else if (r < 78) begin
      // topic length claims more than the frame carries
      pl = $urandom_range(0, 18);
      build_publish(0, pl, nb, 2 + pl);
      tl = $urandom_range(pl + 1, 65535);
      frame_q[frame_q.size() - pl - 2] = 8'(tl >> 8);
      frame_q[frame_q.size() - pl - 1] = 8'(tl);
    end else if (r < 85) begin
      frame_q.delete();
      frame_q.push_back({PUBLISH_TYPE, 4'($urandom)});
      for (k = 0; k < 4; k++) frame_q.push_back({1'b1, 7'($urandom)});
      extra = $urandom_range(0, 6);
      for (k = 0; k < extra; k++) frame_q.push_back(8'($urandom));
    end else if (r < 90) begin
      build_publish(tl, pl, nb, 2 + tl + pl);
      do frame_q[0] = 8'($urandom); while (frame_q[0][7:4] == PUBLISH_TYPE);
    end else begin
      frame_q.delete();
      cut = $urandom_range(1, 10);
      for (k = 0; k < cut; k++) frame_q.push_back(8'($urandom));
    end
  endfunction

  initial begin
    int nframes, start;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    tx_burst = 0;
    rx_burst = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    frame_q = '{8'h30, 8'h03, 8'h00, 8'h00, 8'hAA};
    send_frame();
    frame_q = '{8'h31};
    send_frame();
    frame_q = '{8'h3F, 8'h00, 8'h00};
    send_frame();
    frame_q = '{8'h20, 8'h03, 8'h00, 8'h00, 8'hAA};
    send_frame();
    frame_q = '{8'h00, 8'h03, 8'h00, 8'h00, 8'h55};
    send_frame();
    frame_q = '{8'hFF, 8'h03, 8'h00, 8'h00, 8'h55};
    send_frame();
    // continuation bit on the fourth length byte, frame ending right there
    frame_q = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    frame_q = '{8'h32, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 8'h02, 8'h03};
    send_frame();
    // frame ends inside the length field
    frame_q = '{8'h30, 8'h80, 8'h80, 8'h80};
    send_frame();
    frame_q = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00};
    send_frame();
    frame_q = '{8'h30, 8'h0A, 8'h00, 8'h03, 8'h41};
    send_frame();
    frame_q = '{8'h30, 8'h80, 8'h80, 8'h00, 8'hAA};
    send_frame();
    frame_q = '{8'h30, 8'h05, 8'h00, 8'h09, 8'h61, 8'h62, 8'h63};
    send_frame();
    frame_q = '{8'h30, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame();
    frame_q = '{8'h30, 8'h03, 8'h00, 8'h02, 8'h61, 8'h62};
    send_frame();
    frame_q = '{8'h3A, 8'h85, 8'h80, 8'h80, 8'h00, 8'h00, 8'h01, 8'h61, 8'h62, 8'h63,
                8'h64};
    send_frame();
    wait_drained();

    nframes = 0;
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      if (nframes % 15 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      tx_burst = ($urandom_range(0, 5) == 0);
      // let the whole pipe drain once mid-run
      if (nframes == 25) wait_drained();
      make_random_frame();
      send_frame();
      nframes++;
    end
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.errors == 0) begin
      $display("mqtt_publish_deframer_core regression: pass");
    end else begin
      $display("mqtt_publish_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_front.sv
hw/rtl/mpd_queue.sv
hw/rtl/mpd_back.sv
hw/rtl/mqtt_publish_deframer_core.sv
hw/rtl/mpd_checker.sv
sim/testbench.sv
